FILE: design/ttbi_pkg.sv
// Package for the tiled texture block interpolator.
// Holds block geometry, tiling masks, descriptor types and packing functions.
// No dependencies.
`default_nettype none

package ttbi_pkg;

  localparam int unsigned BLOCK_SIDE = 8;
  localparam int unsigned POS_W      = $clog2(BLOCK_SIDE);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned SHADE_W    = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_SIDE - 1);

  // Tiled-form masks: u and v bits sit apart so one add forms the address
  localparam logic [WORD_W-1:0] TILE_U_HIGH_MASK = 32'hf800_0000;
  localparam logic [WORD_W-1:0] TILE_FRAC_MASK   = 32'h0000_7fff;
  localparam logic [WORD_W-1:0] TILE_U_LOW_MASK  = 32'h0007_0000;
  localparam logic [WORD_W-1:0] TILE_V_MASK      = 32'h07f8_0000;
  localparam logic [WORD_W-1:0] FILL_U           = 32'h07f8_8000;
  localparam logic [WORD_W-1:0] FILL_V           = 32'hf807_8000;
  localparam logic [WORD_W-1:0] KEEP_U           = 32'hf807_7fff;
  localparam logic [WORD_W-1:0] KEEP_V           = 32'h07f8_7fff;

  typedef logic [WORD_W-1:0] word_t;

  // Values along the left and right edges of one row
  typedef struct packed {
    word_t u_l;
    word_t u_r;
    word_t v_l;
    word_t v_r;
    word_t l_l;
    word_t l_r;
  } edge_t;

  // One block as queued between front and back
  typedef struct packed {
    edge_t base;
    edge_t delta;
  } blk_desc_t;

  // Queue handshake between the front and the back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  function automatic word_t sra3(input word_t x);
    sra3 = word_t'($signed(x) >>> 3);
  endfunction

  // Masks are disjoint, so the sums of the packing reduce to ORs
  function automatic word_t pack_u(input word_t x);
    pack_u = ((x << 8) & TILE_U_HIGH_MASK) | ((x >> 1) & TILE_FRAC_MASK)
           | (x & TILE_U_LOW_MASK);
  endfunction

  function automatic word_t pack_v(input word_t x);
    pack_v = ((x << 3) & TILE_V_MASK) | ((x >> 1) & TILE_FRAC_MASK);
  endfunction

  function automatic edge_t edge_add(input edge_t a, input edge_t b);
    edge_add.u_l = a.u_l + b.u_l;
    edge_add.u_r = a.u_r + b.u_r;
    edge_add.v_l = a.v_l + b.v_l;
    edge_add.v_r = a.v_r + b.v_r;
    edge_add.l_l = a.l_l + b.l_l;
    edge_add.l_r = a.l_r + b.l_r;
  endfunction

endpackage

`default_nettype wire

FILE: design/ttbi_if.sv
// Channel interfaces of the tiled texture block interpolator.
// Block beats in, pixel beats out; depends on ttbi_pkg.
`default_nettype none

interface ttbi_in_if
  import ttbi_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t u_top_left;
  word_t u_top_right;
  word_t u_bottom_left;
  word_t u_bottom_right;
  word_t v_top_left;
  word_t v_top_right;
  word_t v_bottom_left;
  word_t v_bottom_right;
  word_t light_top_left;
  word_t light_top_right;
  word_t light_bottom_left;
  word_t light_bottom_right;

  modport source (
    output valid,
    input  ready,
    output u_top_left, u_top_right, u_bottom_left, u_bottom_right,
    output v_top_left, v_top_right, v_bottom_left, v_bottom_right,
    output light_top_left, light_top_right, light_bottom_left, light_bottom_right
  );

  modport sink (
    input  valid,
    output ready,
    input  u_top_left, u_top_right, u_bottom_left, u_bottom_right,
    input  v_top_left, v_top_right, v_bottom_left, v_bottom_right,
    input  light_top_left, light_top_right, light_bottom_left, light_bottom_right
  );
endinterface

interface ttbi_out_if
  import ttbi_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  texel_address;
  logic [SHADE_W-1:0] shade_level;
  logic [POS_W-1:0]   pixel_column;
  logic [POS_W-1:0]   pixel_row;
  logic               last_pixel;

  modport source (
    output valid,
    input  ready,
    output texel_address, shade_level, pixel_column, pixel_row, last_pixel
  );

  modport sink (
    input  valid,
    output ready,
    input  texel_address, shade_level, pixel_column, pixel_row, last_pixel
  );
endinterface

`default_nettype wire

FILE: design/ttbi_front.sv
// Front end: accepts block beats and forms the edge gradients.
// Depends on ttbi_pkg and ttbi_in_if.
`default_nettype none

module ttbi_front
  import ttbi_pkg::*;
(
  ttbi_in_if.sink   in_blk,
  input  logic      q_full,
  output logic      push,
  output blk_desc_t desc
);

  // Take a block whenever the queue has room
  assign in_blk.ready = !q_full;
  assign push         = in_blk.valid && !q_full;

  // Top corners seed the edges
  assign desc.base.u_l = in_blk.u_top_left;
  assign desc.base.u_r = in_blk.u_top_right;
  assign desc.base.v_l = in_blk.v_top_left;
  assign desc.base.v_r = in_blk.v_top_right;
  assign desc.base.l_l = in_blk.light_top_left;
  assign desc.base.l_r = in_blk.light_top_right;

  // Edge gradients: (bottom - top) / 8, arithmetic
  assign desc.delta.u_l = sra3(in_blk.u_bottom_left      - in_blk.u_top_left);
  assign desc.delta.u_r = sra3(in_blk.u_bottom_right     - in_blk.u_top_right);
  assign desc.delta.v_l = sra3(in_blk.v_bottom_left      - in_blk.v_top_left);
  assign desc.delta.v_r = sra3(in_blk.v_bottom_right     - in_blk.v_top_right);
  assign desc.delta.l_l = sra3(in_blk.light_bottom_left  - in_blk.light_top_left);
  assign desc.delta.l_r = sra3(in_blk.light_bottom_right - in_blk.light_top_right);

endmodule

`default_nettype wire

FILE: design/ttbi_queue.sv
// Two-entry block queue between front and back ends.
// Depends on ttbi_pkg.
`default_nettype none

module ttbi_queue
  import ttbi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_ctl_t    ctl,
  input  blk_desc_t wr_desc,
  output blk_desc_t rd_desc,
  output logic      full,
  output logic      empty
);

  blk_desc_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QPTR_W:0]         count_r;
  logic [QPTR_W:0]         count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_desc = mem_r[rd_ptr_r];

  // Store a block on push
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!ctl.push && ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/ttbi_back.sv
// Back end: walks the 8x8 block one pixel per cycle in tiled form, unless the output stalls.
// Depends on ttbi_pkg and ttbi_out_if.
`default_nettype none

module ttbi_back
  import ttbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  blk_desc_t  desc,
  input  logic       q_empty,
  output logic       pop,
  ttbi_out_if.source out_pix
);

  logic               active_r;
  logic [POS_W-1:0]   col_r;
  logic [POS_W-1:0]   row_r;
  edge_t              edges_r;      // edges of the next row
  edge_t              delta_r;
  word_t              tu_r, tv_r, tsu_r, tsv_r, light_r, sl_r;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [SHADE_W-1:0] shade_r;
  logic [POS_W-1:0]   ocol_r, orow_r;
  logic               last_r;

  logic   adv, step, col_end, blk_end, row_next, load;
  edge_t  src, dsrc, edges_nxt;
  word_t  sum, light_nxt;

  assign adv      = !out_valid_r || out_pix.ready;
  assign step     = active_r && adv;
  assign col_end  = (col_r == LAST_POS);
  assign blk_end  = step && col_end && (row_r == LAST_POS);
  assign row_next = step && col_end && (row_r != LAST_POS);
  assign load     = (!active_r || blk_end) && !q_empty;
  assign pop      = load;

  // Row set-up source: a fresh block or the stepped edges
  assign src       = load ? desc.base  : edges_r;
  assign dsrc      = load ? desc.delta : delta_r;
  assign edges_nxt = edge_add(src, dsrc);

  assign sum       = tu_r + tv_r;
  assign light_nxt = light_r + sl_r;

  // Control: block and pixel position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
        col_r    <= '0;
        row_r    <= '0;
      end else begin
        if (blk_end) begin
          active_r <= 1'b0;
        end
        if (step) begin
          col_r <= col_r + 1'b1;
          if (col_end) begin
            row_r <= row_r + 1'b1;
          end
        end
      end
    end
  end

  // Datapath: set up a row or step across it
  always_ff @(posedge clk) begin
    if (load) begin
      delta_r <= desc.delta;
    end
    if (load || row_next) begin
      edges_r <= edges_nxt;
      tu_r    <= pack_u(src.u_l);
      tv_r    <= pack_v(src.v_l);
      tsu_r   <= pack_u(sra3(src.u_r - src.u_l)) | FILL_U;
      tsv_r   <= pack_v(sra3(src.v_r - src.v_l)) | FILL_V;
      sl_r    <= sra3(src.l_r - src.l_l);
      light_r <= src.l_l;
    end else if (step) begin
      tu_r    <= (tu_r + tsu_r) & KEEP_U;
      tv_r    <= (tv_r + tsv_r) & KEEP_V;
      light_r <= light_nxt;
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      addr_r  <= sum[WORD_W-1 -: ADDR_W];
      shade_r <= light_nxt[16 +: SHADE_W];
      ocol_r  <= col_r;
      orow_r  <= row_r;
      last_r  <= col_end && (row_r == LAST_POS);
    end
  end

  assign out_pix.valid         = out_valid_r;
  assign out_pix.texel_address = addr_r;
  assign out_pix.shade_level   = shade_r;
  assign out_pix.pixel_column  = ocol_r;
  assign out_pix.pixel_row     = orow_r;
  assign out_pix.last_pixel    = last_r;

endmodule

`default_nettype wire

FILE: design/tiled_texture_block_interpolator.sv
// Top level of the tiled texture block interpolator.
// Depends on ttbi_pkg, ttbi_if, ttbi_front, ttbi_queue and ttbi_back.
//
// Each input beat carries 16.16 u, v and light values at the corners of an
// 8x8 screen block; the block returns 64 pixel beats in row-major order,
// each with a tiled 64K texel address, a 6-bit shade level, the pixel's
// column and row, and last_pixel on the final one. The pixel stepper emits
// one pixel per cycle unless the output stalls; with a block waiting in
// the two-entry queue the next block's first pixel follows the previous
// block's last with no gap. A block taken into an idle design passes the
// queue, row set-up and output registers. Up to two blocks are taken
// ahead of the one in progress; a stalled output holds the current pixel.
`default_nettype none

module tiled_texture_block_interpolator
  import ttbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ttbi_in_if.sink    in_blk,
  ttbi_out_if.source out_pix
);

  blk_desc_t wr_desc;
  blk_desc_t rd_desc;
  q_ctl_t    q_ctl;
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;

  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  // Accept blocks and form gradients
  ttbi_front u_front (
    .in_blk (in_blk),
    .q_full (q_full),
    .push   (push),
    .desc   (wr_desc)
  );

  // Decouple front and back
  ttbi_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_desc (wr_desc),
    .rd_desc (rd_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Step pixels out
  ttbi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .desc    (rd_desc),
    .q_empty (q_empty),
    .pop     (pop),
    .out_pix (out_pix)
  );

endmodule

`default_nettype wire
